/* rtl/record_ring_drop_oldest_assert.svh */
// assertion macros shared by the ring buffer rtl
`ifndef RECORD_RING_DROP_OLDEST_ASSERT_SVH
`define RECORD_RING_DROP_OLDEST_ASSERT_SVH

// condition must hold on every clock edge out of reset
`define RRDO_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RRDO_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RRDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rrdo_pkg.sv */
`default_nettype none

package rrdo_pkg;

    // request kinds
    typedef enum logic [1:0] {
        K_WR_START = 2'd0,
        K_WR_BYTE  = 2'd1,
        K_RD_START = 2'd2,
        K_RD_BYTE  = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_BUSY = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WS_ABANDON,
        S_WS_CHK,
        S_WALK_LO,
        S_WALK_HI,
        S_HDR0,
        S_HDR1,
        S_HDR2,
        S_RS_ABANDON,
        S_RS_CHK,
        S_RS_LVL,
        S_RS_LO,
        S_RS_HI,
        S_RS_FIN,
        S_RB
    } t_state;

    // register map: bit 2 of the byte address selects the register
    localparam logic       CFG_IDX_STORE_LEVEL = 1'b0;
    localparam logic [2:0] STORE_LEVEL_RST     = 3'd6;

endpackage

`default_nettype wire

/* rtl/record_ring_drop_oldest.sv */
// steps: write byte, filtered or busy results are registered on the accept edge; read
// byte via S_RB; read start via S_RS_ABANDON, S_RS_CHK (done on an empty ring), then
// S_RS_LVL to S_RS_FIN; write start via S_WS_ABANDON, S_WS_CHK, S_WALK_LO and S_WALK_HI
// per oldest record dropped, S_HDR0 to S_HDR2; one request at a time, taken in S_IDLE;
// write bytes 1 per cycle while results are taken; reset: synchronous active low; ring
// empty, no open write or read, store_level = 6, ring memory contents are not cleared
`default_nettype none

module record_ring_drop_oldest #(
    parameter int RING_BYTES = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [2:0]                        i_level,
    input  wire logic [15:0]                       i_length,
    input  wire logic [15:0]                       i_capacity,
    input  wire logic [7:0]                        i_data_in,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_status,
    output logic [$clog2(RING_BYTES)-1:0]          o_length_out,
    output logic [2:0]                             o_level_out,
    output logic [7:0]                             o_data_out,
    output logic                                   o_last,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import rrdo_pkg::*;

    `include "record_ring_drop_oldest_assert.svh"

    localparam int             PW      = $clog2(RING_BYTES);
    localparam int             PW1     = PW + 1;
    localparam logic [PW:0]    RING_N  = PW1'(RING_BYTES);
    localparam logic [16:0]    MAX_L17 = 17'(RING_BYTES - 4);
    localparam logic [PW-1:0]  MAX_LEN = PW'(RING_BYTES - 4);
    localparam logic [PW-1:0]  ONE     = PW'(1);
    localparam logic [PW-1:0]  TWO     = PW'(2);
    localparam logic [PW-1:0]  THREE   = PW'(3);

    // pointer advance modulo the ring size, both operands below the ring size
    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p, input logic [PW-1:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= RING_N) begin
            s = s - RING_N;
        end
        return s[PW-1:0];
    endfunction

    // free bytes with one byte always kept open
    function automatic logic [PW:0] f_free(input logic [PW-1:0] rp, input logic [PW-1:0] wp);
        logic [PW:0] f;
        if (wp >= rp) begin
            f = RING_N - ({1'b0, wp} - {1'b0, rp}) - PW1'(1);
        end else begin
            f = {1'b0, rp} - {1'b0, wp} - PW1'(1);
        end
        return f;
    endfunction

    // ring memory, one write and one registered read per cycle
    logic [7:0]    r_ring [RING_BYTES];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [PW-1:0] mem_raddr;

    // control state
    t_state        r_state, n_state;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_write_left, n_write_left;
    logic [PW-1:0] r_copy_left, n_copy_left;
    logic [PW-1:0] r_skip_left, n_skip_left;
    logic [2:0]    r_store_level;
    logic          r_out_valid, n_out_valid;

    // per-request working registers
    logic [2:0]    r_level, n_level;
    logic [PW-1:0] r_len, n_len;
    logic [15:0]   r_cap, n_cap;
    logic [7:0]    r_lo, n_lo;

    // result register
    t_status       r_status, n_status;
    logic [PW-1:0] r_len_out, n_len_out;
    logic [2:0]    r_level_out, n_level_out;
    logic [7:0]    r_data_out, n_data_out;
    logic          r_last, n_last;
    logic          res_load;

    logic          in_acc;
    logic          cfg_wr;
    logic [15:0]   hdr_len;
    logic [15:0]   cap_m1;
    logic [15:0]   to_copy;
    logic [15:0]   len16;
    logic [PW:0]   need;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    // header length is the byte just read on top of the captured low byte
    assign hdr_len = {r_rdata, r_lo};
    assign cap_m1  = r_cap - 16'd1;
    assign to_copy = (hdr_len > cap_m1) ? cap_m1 : hdr_len;
    assign len16   = 16'(r_len);
    assign need    = {1'b0, r_len} + PW1'(3);

    // sequencer: next state, memory access and result
    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_write_left = r_write_left;
        n_copy_left  = r_copy_left;
        n_skip_left  = r_skip_left;
        n_level      = r_level;
        n_len        = r_len;
        n_cap        = r_cap;
        n_lo         = r_lo;
        mem_we       = 1'b0;
        mem_waddr    = r_wp;
        mem_wdata    = i_data_in;
        mem_raddr    = r_rp;
        res_load     = 1'b0;
        n_status     = ST_NONE;
        n_len_out    = '0;
        n_level_out  = '0;
        n_data_out   = '0;
        n_last       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_kind'(i_kind))
                        K_WR_START: begin
                            if (r_write_left != '0) begin
                                res_load = 1'b1;
                                n_status = ST_BUSY;
                            end else if (i_level > r_store_level) begin
                                // filtered record
                                res_load = 1'b1;
                            end else begin
                                n_level = i_level;
                                n_len   = ({1'b0, i_length} > MAX_L17) ? MAX_LEN
                                                                       : i_length[PW-1:0];
                                n_state = S_WS_ABANDON;
                            end
                        end
                        K_WR_BYTE: begin
                            res_load = 1'b1;
                            if (r_write_left != '0) begin
                                mem_we       = 1'b1;
                                n_wp         = f_wrap(r_wp, ONE);
                                n_write_left = r_write_left - ONE;
                                n_status     = ST_OK;
                            end
                        end
                        K_RD_START: begin
                            if (r_write_left != '0) begin
                                res_load = 1'b1;
                                n_status = ST_BUSY;
                            end else if (i_capacity == 16'd0) begin
                                res_load = 1'b1;
                            end else begin
                                n_cap   = i_capacity;
                                n_state = S_RS_ABANDON;
                            end
                        end
                        K_RD_BYTE: begin
                            if (r_write_left != '0) begin
                                res_load = 1'b1;
                                n_status = ST_BUSY;
                            end else if (r_copy_left == '0) begin
                                res_load = 1'b1;
                            end else begin
                                mem_raddr = r_rp;
                                n_state   = S_RB;
                            end
                        end
                    endcase
                end
            end
            // drop whatever is left of an open read
            S_WS_ABANDON, S_RS_ABANDON: begin
                n_rp        = f_wrap(r_rp, r_copy_left + r_skip_left);
                n_copy_left = '0;
                n_skip_left = '0;
                n_state     = (r_state == S_WS_ABANDON) ? S_WS_CHK : S_RS_CHK;
            end
            // room check, else fetch the length of the oldest record
            S_WS_CHK: begin
                if (f_free(r_rp, r_wp) >= need) begin
                    n_state = S_HDR0;
                end else begin
                    mem_raddr = f_wrap(r_rp, ONE);
                    n_state   = S_WALK_LO;
                end
            end
            S_WALK_LO: begin
                n_lo      = r_rdata;
                mem_raddr = f_wrap(r_rp, TWO);
                n_state   = S_WALK_HI;
            end
            S_WALK_HI: begin
                n_rp    = f_wrap(r_rp, hdr_len[PW-1:0] + THREE);
                n_state = S_WS_CHK;
            end
            S_HDR0: begin
                mem_we    = 1'b1;
                mem_wdata = {5'd0, r_level};
                n_wp      = f_wrap(r_wp, ONE);
                n_state   = S_HDR1;
            end
            S_HDR1: begin
                mem_we    = 1'b1;
                mem_wdata = len16[7:0];
                n_wp      = f_wrap(r_wp, ONE);
                n_state   = S_HDR2;
            end
            S_HDR2: begin
                mem_we       = 1'b1;
                mem_wdata    = len16[15:8];
                n_wp         = f_wrap(r_wp, ONE);
                n_write_left = r_len;
                res_load     = 1'b1;
                n_status     = ST_OK;
                n_len_out    = r_len;
                n_state      = S_IDLE;
            end
            S_RS_CHK: begin
                if (r_rp == r_wp) begin
                    // empty ring
                    res_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = r_rp;
                    n_state   = S_RS_LVL;
                end
            end
            S_RS_LVL: begin
                n_level   = r_rdata[2:0];
                mem_raddr = f_wrap(r_rp, ONE);
                n_state   = S_RS_LO;
            end
            S_RS_LO: begin
                n_lo      = r_rdata;
                mem_raddr = f_wrap(r_rp, TWO);
                n_state   = S_RS_HI;
            end
            S_RS_HI: begin
                n_copy_left = to_copy[PW-1:0];
                n_skip_left = hdr_len[PW-1:0] - to_copy[PW-1:0];
                n_state     = S_RS_FIN;
            end
            S_RS_FIN: begin
                // nothing to copy: skip the whole payload now
                if (r_copy_left == '0) begin
                    n_rp        = f_wrap(r_rp, r_skip_left + THREE);
                    n_skip_left = '0;
                end else begin
                    n_rp = f_wrap(r_rp, THREE);
                end
                res_load    = 1'b1;
                n_status    = ST_OK;
                n_len_out   = r_copy_left;
                n_level_out = r_level;
                n_state     = S_IDLE;
            end
            S_RB: begin
                res_load    = 1'b1;
                n_status    = ST_OK;
                n_data_out  = r_rdata;
                n_copy_left = r_copy_left - ONE;
                if (r_copy_left == ONE) begin
                    n_last      = 1'b1;
                    n_rp        = f_wrap(r_rp, r_skip_left + ONE);
                    n_skip_left = '0;
                end else begin
                    n_rp = f_wrap(r_rp, ONE);
                end
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = res_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_rp         <= '0;
            r_write_left <= '0;
            r_copy_left  <= '0;
            r_skip_left  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_write_left <= n_write_left;
            r_copy_left  <= n_copy_left;
            r_skip_left  <= n_skip_left;
            r_out_valid  <= n_out_valid;
        end
    end

    // working and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_len   <= n_len;
        r_cap   <= n_cap;
        r_lo    <= n_lo;
        if (res_load) begin
            r_status    <= n_status;
            r_len_out   <= n_len_out;
            r_level_out <= n_level_out;
            r_data_out  <= n_data_out;
            r_last      <= n_last;
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_ring[mem_raddr];
    end

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_STORE_LEVEL);
    assign prdata = (paddr[2] == CFG_IDX_STORE_LEVEL) ? {29'd0, r_store_level} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_level <= STORE_LEVEL_RST;
        end else if (cfg_wr) begin
            r_store_level <= pwdata[2:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_length_out = r_len_out;
    assign o_level_out  = r_level_out;
    assign o_data_out   = r_data_out;
    assign o_last       = r_last;

    // an open write always follows an abandoned read
    `RRDO_ASSERT_IMPLIES(a_write_excludes_read, i_clk, i_rst_n, r_write_left != '0, (r_copy_left == '0) && (r_skip_left == '0), "copy state left open during a write")

    // each stored payload byte counts down the open record
    `RRDO_ASSERT_NEXT(a_write_byte_count, i_clk, i_rst_n, in_acc && (i_kind == K_WR_BYTE) && (r_write_left != '0), r_write_left == $past(r_write_left) - ONE, "write byte did not count down")

    // pointers stay inside the ring
    `RRDO_ASSERT_ALWAYS(a_ptr_range, i_clk, i_rst_n, ({1'b0, r_rp} < RING_N) && ({1'b0, r_wp} < RING_N), "ring pointer out of range")

    // the last byte of a copy closes the read
    `RRDO_ASSERT_IMPLIES(a_last_closes_copy, i_clk, i_rst_n, r_out_valid && r_last, (r_copy_left == '0) && (r_skip_left == '0), "copy still open after last byte")

endmodule

`default_nettype wire
